### src/smes_pkg.sv
// types and constants shared by the sparse matrix entry store
`default_nettype none

package smes_pkg;

  localparam int ROW_W = 16;
  localparam int COL_W = 16;
  localparam int VAL_W = 32;
  localparam int ENTRY_W = ROW_W + COL_W + VAL_W;

  localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    cmd_t                     command;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         column;
    logic signed [VAL_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  read_value;
    logic                     hit;
    logic                     rejected;
  } rsp_t;

  typedef struct packed {
    logic idle;
    logic full;
  } status_t;

endpackage

`default_nettype wire

### src/sparse_matrix_entry_store_core.sv
// top level of the sparse matrix entry store with request and response channels
//
//   channel   signals                          payload
//   request   req_valid / req_stall            command, row, column, value
//   response  rsp_valid / rsp_stall            read_value, hit, rejected
//
// after a request transfers, the entry memory is scanned one key per cycle up to
// the matching slot or the fill count, so a scan reads 1 to ENTRIES keys;
// req_stall stays high until the result is handed to the response register
// reset clears only the fill count and control, so no clearing pass is needed
// the response sits in an output register, so a new request may transfer
// while the previous response is stalled
`default_nettype none

module sparse_matrix_entry_store_core #(
  parameter int ENTRIES = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic                                command,
  input  logic [smes_pkg::ROW_W-1:0]          row,
  input  logic [smes_pkg::COL_W-1:0]          column,
  input  logic signed [smes_pkg::VAL_W-1:0]   value,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic signed [smes_pkg::VAL_W-1:0]   read_value,
  output logic                                hit,
  output logic                                rejected
);
  import smes_pkg::*;

  req_t    req_in;
  rsp_t    res;
  rsp_t    rsp;
  status_t status;
  logic    start;
  logic    res_valid;
  logic    res_ready;
  logic    load;
  logic    rsp_valid_next;

  assign req_in.command = cmd_t'(command);
  assign req_in.row     = row;
  assign req_in.column  = column;
  assign req_in.value   = value;

  assign req_stall = !status.idle;
  assign start     = req_valid && !req_stall;

  smes_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_in    (req_in),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .status    (status)
  );

  assign res_ready = !rsp_valid || !rsp_stall;
  assign load      = res_valid && res_ready;

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (load) rsp_valid_next = 1'b1;
    else if (!rsp_stall) rsp_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) rsp <= res;
  end

  assign read_value = rsp.read_value;
  assign hit        = rsp.hit;
  assign rejected   = rsp.rejected;

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> !status.idle)
    else $error("table idle right after request transfer");

  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    load && res.rejected |-> status.full)
    else $error("insert rejected while table not full");

  a_hit_reject: assert property (@(posedge clk) disable iff (rst)
    load |-> !(res.hit && res.rejected))
    else $error("response both hit and rejected");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    load |=> status.idle)
    else $error("table not idle after response handoff");

endmodule

`default_nettype wire

### src/smes_table.sv
// entry memory, fill count and key scan sequencer
`default_nettype none

module smes_table #(
  parameter int ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  smes_pkg::req_t    req_in,
  output smes_pkg::rsp_t    res,
  output logic              res_valid,
  input  logic              res_ready,
  output smes_pkg::status_t status
);
  import smes_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic [ENTRY_W-1:0] mem [ENTRIES];
  logic [ENTRY_W-1:0] rd_data;

  state_t             state;
  state_t             state_next;
  req_t               req;
  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   rd_idx_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  rsp_t               result;
  rsp_t               result_next;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  logic [ROW_W-1:0]         rd_row;
  logic [COL_W-1:0]         rd_column;
  logic signed [VAL_W-1:0]  rd_value;
  logic                     in_range;
  logic                     match;
  logic                     last;
  logic                     finish;

  assign rd_row    = rd_data[ENTRY_W-1 -: ROW_W];
  assign rd_column = rd_data[VAL_W +: COL_W];
  assign rd_value  = rd_data[VAL_W-1:0];

  assign in_range = CNT_W'(rd_idx) < count;
  assign match    = in_range && (rd_row == req.row) && (rd_column == req.column);
  assign last     = !in_range || ((CNT_W'(rd_idx) + CNT_W'(1)) == count);
  assign finish   = match || last;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (finish) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    rd_idx_next = rd_idx;
    count_next  = count;
    result_next = result;
    mem_we      = 1'b0;
    mem_waddr   = rd_idx;
    mem_wdata   = {req.row, req.column, req.value};
    unique case (state)
      ST_IDLE: begin
        if (start) rd_idx_next = '0;
      end
      ST_SCAN: begin
        if (!finish) begin
          rd_idx_next = rd_idx + IDX_W'(1);
        end else begin
          result_next.read_value = MISS_VALUE;
          result_next.hit        = 1'b0;
          result_next.rejected   = 1'b0;
          if (req.command == CMD_LOOKUP) begin
            if (match) begin
              result_next.read_value = rd_value;
              result_next.hit        = 1'b1;
            end
          end else if (match) begin
            mem_we = 1'b1;
          end else if (count < CNT_W'(ENTRIES)) begin
            mem_we     = 1'b1;
            mem_waddr  = count[IDX_W-1:0];
            count_next = count + CNT_W'(1);
          end else begin
            result_next.rejected = 1'b1;
          end
        end
      end
      ST_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[rd_idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) req <= req_in;
    rd_idx <= rd_idx_next;
    result <= result_next;
  end

  assign res         = result;
  assign res_valid   = (state == ST_HOLD);
  assign status.idle = (state == ST_IDLE);
  assign status.full = (count == CNT_W'(ENTRIES));

endmodule

`default_nettype wire
